// ===== design/fmpd_pkg.sv =====
// Shared types, constants and the arctangent table for the FM polar discriminator.
// No dependencies; every other design file refers to this package by scoped names.
package fmpd_pkg;

  // vector magnitude is scaled up until its larger component reaches 2^NORM_TOP
  localparam int unsigned NORM_TOP     = 40;
  localparam int unsigned CORDIC_STEPS = 31;
  // datapath widths: x grows by the CORDIC gain, z spans a little over +-pi
  localparam int unsigned XW = NORM_TOP + 4;
  localparam int unsigned ZW = 35;

  // angles in units of pi/2^31
  localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'h8000_0000);
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'h4000_0000);
  localparam logic signed [XW-1:0] NORM_MIN     = XW'(64'h100_0000_0000);

  typedef struct packed {
    logic                 vld;
    logic                 fixed;   // angle already known, cells pass it through
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } fmpd_vec_t;

  // atan(2^-k) rounded to pi/2^31 units
  function automatic logic [31:0] atan_unit(input int unsigned k);
    logic [31:0] a;
    case (k)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051E;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2F;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2FA;
      15:      a = 32'h0000_517D;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A30;
      19:      a = 32'h0000_0518;
      20:      a = 32'h0000_028C;
      21:      a = 32'h0000_0146;
      22:      a = 32'h0000_00A3;
      23:      a = 32'h0000_0051;
      24:      a = 32'h0000_0029;
      25:      a = 32'h0000_0014;
      26:      a = 32'h0000_000A;
      27:      a = 32'h0000_0005;
      28:      a = 32'h0000_0003;
      29:      a = 32'h0000_0001;
      30:      a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

// ===== design/fm_polar_discriminator.sv =====
// FM polar discriminator: angle of x[n] * conj(x[n-1]) per I/Q sample.
// Instantiates fmpd_front, fmpd_norm and a chain of fmpd_cordic_cell; uses fmpd_pkg.
//
// Input stream: s_axis_tdata carries I and Q raw samples, s_axis_tuser marks the
// first sample of a block, which is only stored. After reset the first sample is
// treated the same way. cfg_we_i/cfg_wdata_i set the sample format (0 offset
// binary, 1 two's complement); write it only while no transfer is in flight.
// Output stream: m_axis_tdata carries the signed angle, 2^(ANGLE_BITS-1) = pi.
//
// Throughput: one transfer per clock while the output is not stalled. The
// pipeline is two front stages (product, quadrant), one normalisation stage,
// 31 CORDIC cells and an output register.
// Block starts leave a bubble and produce nothing.
// A stall on the output freezes the whole chain and drops s_axis_tready until
// the held result is taken; nothing is lost or repeated.
// Reset clears the held sample, the format (offset binary) and all valid bits.
module fm_polar_discriminator #(
  parameter int unsigned SAMPLE_BITS = 8,
  parameter int unsigned ANGLE_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [SAMPLE_BITS-1:0] i_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] q_sample
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // [0] starts_block
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [ANGLE_BITS-1:0] angle
  output logic [((ANGLE_BITS+7)/8)*8-1:0]     m_axis_tdata
);

  localparam int unsigned OW    = ((ANGLE_BITS + 7) / 8) * 8;
  localparam int unsigned SH    = 32 - ANGLE_BITS;
  localparam int unsigned ZW    = fmpd_pkg::ZW;
  localparam int unsigned STEPS = fmpd_pkg::CORDIC_STEPS;

  logic adv, acc;
  fmpd_pkg::fmpd_vec_t front_vec;
  fmpd_pkg::fmpd_vec_t chain [STEPS+1];
  fmpd_pkg::fmpd_vec_t last;

  logic                  out_vld_q;
  logic [ANGLE_BITS-1:0] angle_q, angle_d;
  logic signed [ZW-1:0]  z_rnd;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  fmpd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .acc_i      (acc),
    .i_raw_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .q_raw_i    (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .start_i    (s_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_o      (front_vec)
  );

  fmpd_norm u_norm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .in_i  (front_vec),
    .out_o (chain[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    fmpd_cordic_cell #(
      .STEP(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .in_i  (chain[k]),
      .out_o (chain[k+1])
    );
  end

  assign last = chain[STEPS];

  // round half up, then keep the angle bits (wraps pi to -pi)
  assign z_rnd   = last.z + ZW'(64'd1 << (SH - 1));
  assign angle_d = z_rnd[31:SH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_q <= angle_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OW'(angle_q);

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[0].vld && !chain[0].fixed |->
      chain[0].x > 0 && (chain[0].x >= fmpd_pkg::NORM_MIN ||
      chain[0].y >= fmpd_pkg::NORM_MIN || chain[0].y <= -fmpd_pkg::NORM_MIN))
    else $error("normalised vector out of range");

  a_cordic_x_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.vld && !last.fixed |-> last.x > 0)
    else $error("CORDIC x component not positive");

  a_fixed_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.vld && last.fixed |->
      last.z == '0 || last.z == fmpd_pkg::HALF_TURN ||
      last.z == fmpd_pkg::QUARTER_TURN || last.z == -fmpd_pkg::QUARTER_TURN)
    else $error("axis-case angle corrupted in chain");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(last.vld))
    else $error("result appeared without a chain item");

endmodule

// ===== design/fmpd_front.sv =====
// Front end: sample conversion, previous-sample store, conjugate product and
// quadrant pre-rotation. Uses fmpd_pkg.
module fmpd_front #(
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   acc_i,
  input  logic [SAMPLE_BITS-1:0] i_raw_i,
  input  logic [SAMPLE_BITS-1:0] q_raw_i,
  input  logic                   start_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  output fmpd_pkg::fmpd_vec_t    out_o
);

  localparam int unsigned SW = SAMPLE_BITS + 1;
  localparam int unsigned MW = 2 * SW;
  localparam int unsigned PW = MW + 1;
  localparam int unsigned XW = fmpd_pkg::XW;
  localparam int unsigned ZW = fmpd_pkg::ZW;

  // offset mode: 2b - (2^N - 1); signed mode: 2b
  function automatic logic signed [SW-1:0] conv(input logic [SAMPLE_BITS-1:0] b,
                                                input logic fmt);
    logic signed [SW-1:0] v;
    if (fmt) begin
      v = {b, 1'b0};
    end else begin
      v = {~b[SAMPLE_BITS-1], b[SAMPLE_BITS-2:0], 1'b1};
    end
    return v;
  endfunction

  logic                 fmt_q;
  logic signed [SW-1:0] prev_i_q, prev_q_q;
  logic                 have_prev_q;
  logic signed [SW-1:0] ci, cq;

  logic                 pa_vld_q;
  logic signed [MW-1:0] ii_q, qq_q, qi_q, iq_q;

  logic                 pb_vld_q;
  logic                 pb_fixed_q, pb_fixed_d;
  logic signed [XW-1:0] pb_x_q, pb_x_d, pb_y_q, pb_y_d;
  logic signed [ZW-1:0] pb_z_q, pb_z_d;

  assign ci = conv(i_raw_i, fmt_q);
  assign cq = conv(q_raw_i, fmt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= 1'b0;
      prev_i_q    <= '0;
      prev_q_q    <= '0;
      have_prev_q <= 1'b0;
      pa_vld_q    <= 1'b0;
      pb_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      if (acc_i) begin
        prev_i_q    <= ci;
        prev_q_q    <= cq;
        have_prev_q <= 1'b1;
      end
      if (adv_i) begin
        pa_vld_q <= acc_i && !start_i && have_prev_q;
        pb_vld_q <= pa_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      ii_q <= ci * prev_i_q;
      qq_q <= cq * prev_q_q;
      qi_q <= cq * prev_i_q;
      iq_q <= ci * prev_q_q;
    end
  end

  always_comb begin
    logic signed [PW-1:0] re, im;
    logic signed [XW-1:0] re_x, im_x;
    re   = PW'(ii_q) + PW'(qq_q);
    im   = PW'(qi_q) - PW'(iq_q);
    re_x = XW'(re);
    im_x = XW'(im);
    pb_fixed_d = 1'b0;
    pb_x_d     = re_x;
    pb_y_d     = im_x;
    pb_z_d     = '0;
    if (im == '0) begin
      pb_fixed_d = 1'b1;
      pb_z_d     = (re < 0) ? fmpd_pkg::HALF_TURN : '0;
    end else if (re == '0) begin
      pb_fixed_d = 1'b1;
      pb_z_d     = (im > 0) ? fmpd_pkg::QUARTER_TURN : -fmpd_pkg::QUARTER_TURN;
    end else if (re < 0) begin
      // turn by -pi/2 or +pi/2 into the right half-plane
      if (im > 0) begin
        pb_x_d = im_x;
        pb_y_d = -re_x;
        pb_z_d = fmpd_pkg::QUARTER_TURN;
      end else begin
        pb_x_d = -im_x;
        pb_y_d = re_x;
        pb_z_d = -fmpd_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pb_fixed_q <= pb_fixed_d;
      pb_x_q     <= pb_x_d;
      pb_y_q     <= pb_y_d;
      pb_z_q     <= pb_z_d;
    end
  end

  always_comb begin
    out_o.vld   = pb_vld_q;
    out_o.fixed = pb_fixed_q;
    out_o.x     = pb_x_q;
    out_o.y     = pb_y_q;
    out_o.z     = pb_z_q;
  end

endmodule

// ===== design/fmpd_norm.sv =====
// Normalisation stage: scales the vector by a power of two until its larger
// component lies in [2^NORM_TOP, 2^(NORM_TOP+1)). Uses fmpd_pkg.
module fmpd_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  fmpd_pkg::fmpd_vec_t in_i,
  output fmpd_pkg::fmpd_vec_t out_o
);

  localparam int unsigned XW = fmpd_pkg::XW;
  localparam int unsigned MTW = fmpd_pkg::NORM_TOP + 1;

  logic                 vld_q;
  fmpd_pkg::fmpd_vec_t  nxt, vec_q;

  // greedy shift by 32,16,..,1 while the top bits of the window stay clear
  always_comb begin
    logic signed [XW-1:0] ay, mx;
    logic [MTW-1:0]       m;
    int unsigned          sh;
    nxt = in_i;
    ay  = (in_i.y < 0) ? -in_i.y : in_i.y;
    mx  = (in_i.x > ay) ? in_i.x : ay;
    m   = mx[MTW-1:0];
    for (int j = 5; j >= 0; j--) begin
      sh = 1 << j;
      if ((m >> (MTW - sh)) == '0) begin
        m     = m << sh;
        nxt.x = nxt.x <<< sh;
        nxt.y = nxt.y <<< sh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vec_q <= nxt;
    end
  end

  always_comb begin
    out_o     = vec_q;
    out_o.vld = vld_q;
  end

endmodule

// ===== design/fmpd_cordic_cell.sv =====
// One vectoring CORDIC step with its pipeline register.
// Step index selects the shift and the arctangent entry from fmpd_pkg.
module fmpd_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  fmpd_pkg::fmpd_vec_t in_i,
  output fmpd_pkg::fmpd_vec_t out_o
);

  localparam int unsigned ZW = fmpd_pkg::ZW;
  localparam logic signed [ZW-1:0] DZ = $signed(ZW'(fmpd_pkg::atan_unit(STEP)));

  logic                vld_q;
  fmpd_pkg::fmpd_vec_t nxt, vec_q;

  // arithmetic shifts give the floor the angle table was built against
  always_comb begin
    nxt = in_i;
    if (!in_i.fixed) begin
      if (in_i.y > 0) begin
        nxt.x = in_i.x + (in_i.y >>> STEP);
        nxt.y = in_i.y - (in_i.x >>> STEP);
        nxt.z = in_i.z + DZ;
      end else begin
        nxt.x = in_i.x - (in_i.y >>> STEP);
        nxt.y = in_i.y + (in_i.x >>> STEP);
        nxt.z = in_i.z - DZ;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vec_q <= nxt;
    end
  end

  always_comb begin
    out_o     = vec_q;
    out_o.vld = vld_q;
  end

endmodule
